### rtl/ehp_pkg.sv
// Shared types and constants for the Ethernet/VLAN/IPv4/L4 header parser.
// No dependencies; imported by ehp_capture, ehp_verdict and the top level.
`default_nettype none

package ehp_pkg;

  typedef enum logic [1:0] {
    PH_ETH,
    PH_TAG,
    PH_IP,
    PH_STOP
  } phase_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
  localparam logic [2:0] ST_BAD_IPHDR = 3'd3;
  localparam logic [2:0] ST_BAD_TOTAL = 3'd4;
  localparam logic [2:0] ST_BAD_L4    = 3'd5;
  localparam logic [2:0] ST_OTHER     = 3'd6;

  localparam logic [15:0] TPID_8021Q  = 16'h8100;
  localparam logic [15:0] TPID_8021AD = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [3:0]  IPV4_VER    = 4'd4;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // byte positions relative to the start of the current header
  localparam logic [15:0] ETH_TYPE_POS = 16'd12;
  localparam logic [15:0] TAG_TYPE_POS = 16'd2;
  localparam logic [15:0] IP_VER_POS   = 16'd0;
  localparam logic [15:0] IP_TLEN_HI   = 16'd2;
  localparam logic [15:0] IP_TLEN_LO   = 16'd3;
  localparam logic [15:0] IP_PROTO_POS = 16'd9;
  localparam logic [15:0] IP_SRC_POS   = 16'd12;
  localparam logic [15:0] IP_DST_POS   = 16'd16;
  localparam logic [15:0] IP_END_POS   = 16'd20;
  localparam logic [15:0] L4_PORT_END  = 16'd4;
  localparam logic [15:0] UDP_LEN_HI   = 16'd4;
  localparam logic [15:0] UDP_LEN_LO   = 16'd5;
  localparam logic [15:0] TCP_DOFF_POS = 16'd12;

  localparam logic [15:0] IP_MIN_HDR  = 16'd20;
  localparam logic [15:0] TCP_MIN_HDR = 16'd20;
  localparam logic [15:0] UDP_HDR     = 16'd8;

  // frame state at the last byte, handed to the verdict stage
  typedef struct packed {
    phase_t      phase;
    logic [15:0] avail;
    logic [15:0] ip_start;
    logic [5:0]  hdr_len;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic        ver_ok;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [15:0] l4_len;
  } snap_t;

endpackage

`default_nettype wire

### rtl/ehp_capture.sv
// Per-byte header field capture: byte counters, EtherType/tag walk, IPv4
// and L4 field registers, and the end-of-frame snapshot register. Uses ehp_pkg.
`default_nettype none

module ehp_capture #(
  parameter int MAX_FRAME = 65535
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_frame,
  input  wire logic          snap_pop,
  output logic               snap_valid,
  output ehp_pkg::snap_t     snap
);
  import ehp_pkg::*;

  localparam logic [15:0] MaxIdx = 16'(MAX_FRAME);

  phase_t      phase_r, phase_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [15:0] rel_r, rel_nxt;
  logic [15:0] ip_start_r, ip_start_nxt;
  logic [7:0]  kind_hi_r, kind_hi_nxt;
  logic [5:0]  hdr_r, hdr_nxt;
  logic [15:0] total_r, total_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic        ver_ok_r, ver_ok_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [31:0] ports_r, ports_nxt;
  logic [15:0] l4_r, l4_nxt;
  logic        snap_valid_r, snap_valid_nxt;
  snap_t       snap_r, snap_nxt;

  logic [15:0] kind_full;
  logic [15:0] type_pos;
  logic [15:0] l4_pos;
  logic        in_l4;

  always_comb begin
    kind_full = {kind_hi_r, data_byte};
    type_pos  = (phase_r == PH_ETH) ? ETH_TYPE_POS : TAG_TYPE_POS;
    l4_pos    = rel_r - {10'd0, hdr_r};
    in_l4     = ({10'd0, hdr_r} >= IP_MIN_HDR) && (rel_r >= {10'd0, hdr_r});

    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    rel_nxt      = rel_r;
    ip_start_nxt = ip_start_r;
    kind_hi_nxt  = kind_hi_r;
    hdr_nxt      = hdr_r;
    total_nxt    = total_r;
    proto_nxt    = proto_r;
    ver_ok_nxt   = ver_ok_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    ports_nxt    = ports_r;
    l4_nxt       = l4_r;
    snap_valid_nxt = snap_valid_r && !snap_pop;
    snap_nxt     = snap_r;

    if (take && (idx_r < MaxIdx)) begin
      idx_nxt = idx_r + 16'd1;
      rel_nxt = rel_r + 16'd1;
      case (phase_r)
        PH_ETH, PH_TAG: begin
          if (rel_r == type_pos) begin
            kind_hi_nxt = data_byte;
          end else if (rel_r == type_pos + 16'd1) begin
            ip_start_nxt = idx_r + 16'd1;
            rel_nxt      = '0;
            if (kind_full inside {TPID_8021Q, TPID_8021AD}) begin
              phase_nxt = PH_TAG;
            end else if (kind_full == ETYPE_IPV4) begin
              phase_nxt = PH_IP;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
        end
        PH_IP: begin
          if (rel_r == IP_VER_POS) begin
            ver_ok_nxt = (data_byte[7:4] == IPV4_VER);
            hdr_nxt    = {data_byte[3:0], 2'b00};
          end else if (rel_r == IP_TLEN_HI) begin
            total_nxt = {data_byte, total_r[7:0]};
          end else if (rel_r == IP_TLEN_LO) begin
            total_nxt = {total_r[15:8], data_byte};
          end else if (rel_r == IP_PROTO_POS) begin
            proto_nxt = data_byte;
          end else if (rel_r >= IP_SRC_POS && rel_r < IP_DST_POS) begin
            src_nxt = {src_r[23:0], data_byte};
          end else if (rel_r >= IP_DST_POS && rel_r < IP_END_POS) begin
            dst_nxt = {dst_r[23:0], data_byte};
          end
          if (in_l4) begin
            if (l4_pos < L4_PORT_END) begin
              ports_nxt = {ports_r[23:0], data_byte};
            end else if (proto_r == PROTO_UDP && l4_pos == UDP_LEN_HI) begin
              l4_nxt = {data_byte, l4_r[7:0]};
            end else if (proto_r == PROTO_UDP && l4_pos == UDP_LEN_LO) begin
              l4_nxt = {l4_r[15:8], data_byte};
            end else if (proto_r == PROTO_TCP && l4_pos == TCP_DOFF_POS) begin
              l4_nxt = {12'd0, data_byte[7:4]};
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (take && end_of_frame) begin
      snap_valid_nxt     = 1'b1;
      snap_nxt.phase     = phase_nxt;
      snap_nxt.avail     = rel_nxt;
      snap_nxt.ip_start  = ip_start_nxt;
      snap_nxt.hdr_len   = hdr_nxt;
      snap_nxt.total_len = total_nxt;
      snap_nxt.proto     = proto_nxt;
      snap_nxt.ver_ok    = ver_ok_nxt;
      snap_nxt.src_addr  = src_nxt;
      snap_nxt.dst_addr  = dst_nxt;
      snap_nxt.ports     = ports_nxt;
      snap_nxt.l4_len    = l4_nxt;
      phase_nxt    = PH_ETH;
      idx_nxt      = '0;
      rel_nxt      = '0;
      ip_start_nxt = '0;
      kind_hi_nxt  = '0;
      hdr_nxt      = '0;
      total_nxt    = '0;
      proto_nxt    = '0;
      ver_ok_nxt   = 1'b0;
      src_nxt      = '0;
      dst_nxt      = '0;
      ports_nxt    = '0;
      l4_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_ETH;
      idx_r        <= '0;
      rel_r        <= '0;
      ip_start_r   <= '0;
      kind_hi_r    <= '0;
      hdr_r        <= '0;
      total_r      <= '0;
      proto_r      <= '0;
      ver_ok_r     <= 1'b0;
      src_r        <= '0;
      dst_r        <= '0;
      ports_r      <= '0;
      l4_r         <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      rel_r        <= rel_nxt;
      ip_start_r   <= ip_start_nxt;
      kind_hi_r    <= kind_hi_nxt;
      hdr_r        <= hdr_nxt;
      total_r      <= total_nxt;
      proto_r      <= proto_nxt;
      ver_ok_r     <= ver_ok_nxt;
      src_r        <= src_nxt;
      dst_r        <= dst_nxt;
      ports_r      <= ports_nxt;
      l4_r         <= l4_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

`default_nettype wire

### rtl/ehp_verdict.sv
// Frame verdict: length and header checks on the end-of-frame snapshot,
// payload offset/length, and the result register. Uses ehp_pkg.
`default_nettype none

module ehp_verdict (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           snap_valid,
  input  wire ehp_pkg::snap_t snap,
  output logic                snap_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [2:0]          out_status,
  output logic                out_is_tcp,
  output logic [31:0]         out_src_addr,
  output logic [31:0]         out_dst_addr,
  output logic [15:0]         out_src_port,
  output logic [15:0]         out_dst_port,
  output logic [15:0]         out_payload_offset,
  output logic [15:0]         out_payload_length
);
  import ehp_pkg::*;

  logic        valid_r, valid_nxt;
  logic [2:0]  status_r;
  logic        is_tcp_r;
  logic [31:0] src_r, dst_r;
  logic [15:0] sport_r, dport_r, off_r, len_r;

  logic [2:0]  st;
  logic        tcp;
  logic [15:0] off, len;
  logic [15:0] hdr16, tlen, doff, ulen, l4_base;
  logic        adv;

  always_comb begin
    hdr16   = {10'd0, snap.hdr_len};
    tlen    = snap.total_len - hdr16;
    doff    = {10'd0, snap.l4_len[3:0], 2'b00};
    ulen    = (snap.l4_len > tlen) ? tlen : snap.l4_len;
    l4_base = snap.ip_start + hdr16;
    st  = ST_OK;
    tcp = 1'b0;
    off = '0;
    len = '0;
    case (snap.phase)
      PH_ETH, PH_TAG: st = ST_TRUNC;
      PH_STOP:        st = ST_NOT_IPV4;
      PH_IP: begin
        if (snap.avail < IP_MIN_HDR || !snap.ver_ok || hdr16 < IP_MIN_HDR ||
            snap.avail < hdr16) begin
          st = ST_BAD_IPHDR;
        end else if (snap.total_len < hdr16 || snap.avail < snap.total_len) begin
          st = ST_BAD_TOTAL;
        end else if (snap.proto == PROTO_TCP) begin
          if (tlen < TCP_MIN_HDR || doff < TCP_MIN_HDR || tlen < doff) begin
            st = ST_BAD_L4;
          end else begin
            tcp = 1'b1;
            off = l4_base + doff;
            len = tlen - doff;
          end
        end else if (snap.proto == PROTO_UDP) begin
          if (tlen < UDP_HDR || snap.l4_len < UDP_HDR) begin
            st = ST_BAD_L4;
          end else begin
            off = l4_base + UDP_HDR;
            len = ulen - UDP_HDR;
          end
        end else begin
          st = ST_OTHER;
        end
      end
      default: st = ST_TRUNC;
    endcase
  end

  assign adv       = snap_valid && (!valid_r || !out_stall);
  assign snap_pop  = adv;
  assign valid_nxt = adv || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= st;
      is_tcp_r <= tcp;
      if (st == ST_OK) begin
        src_r   <= snap.src_addr;
        dst_r   <= snap.dst_addr;
        sport_r <= snap.ports[31:16];
        dport_r <= snap.ports[15:0];
        off_r   <= off;
        len_r   <= len;
      end else begin
        src_r   <= '0;
        dst_r   <= '0;
        sport_r <= '0;
        dport_r <= '0;
        off_r   <= '0;
        len_r   <= '0;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_is_tcp         = is_tcp_r;
  assign out_src_addr       = src_r;
  assign out_dst_addr       = dst_r;
  assign out_src_port       = sport_r;
  assign out_dst_port       = dport_r;
  assign out_payload_offset = off_r;
  assign out_payload_length = len_r;

endmodule

`default_nettype wire

### rtl/eth_vlan_ipv4_l4_header_parser.sv
// Ethernet/VLAN/IPv4/TCP-UDP header parser, top level. Uses ehp_pkg,
// ehp_capture and ehp_verdict.
// Throughput: one byte per cycle; input stalls only while a held snapshot meets a stalled result.
// Result path: the snapshot loads at the edge that accepts the last byte, and the result
// register loads from it once the result register is empty or not stalled; out_valid follows that register.
// Reset (rst_n, synchronous): clears parser state and both valid flags.
`default_nettype none

module eth_vlan_ipv4_l4_header_parser #(
  parameter int MAX_FRAME = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_frame,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_is_tcp,
  output logic [31:0]      out_src_addr,
  output logic [31:0]      out_dst_addr,
  output logic [15:0]      out_src_port,
  output logic [15:0]      out_dst_port,
  output logic [15:0]      out_payload_offset,
  output logic [15:0]      out_payload_length
);
  import ehp_pkg::*;

  snap_t snap;
  logic  snap_valid;
  logic  snap_pop;
  logic  take;

  assign in_stall = snap_valid && !snap_pop;
  assign take     = in_valid && !in_stall;

  ehp_capture #(
    .MAX_FRAME(MAX_FRAME)
  ) u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .data_byte    (in_data_byte),
    .end_of_frame (in_end_of_frame),
    .snap_pop     (snap_pop),
    .snap_valid   (snap_valid),
    .snap         (snap)
  );

  ehp_verdict u_verdict (
    .clk                (clk),
    .rst_n              (rst_n),
    .snap_valid         (snap_valid),
    .snap               (snap),
    .snap_pop           (snap_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_is_tcp         (out_is_tcp),
    .out_src_addr       (out_src_addr),
    .out_dst_addr       (out_dst_addr),
    .out_src_port       (out_src_port),
    .out_dst_port       (out_dst_port),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length)
  );

endmodule

`default_nettype wire
